// File: sv/ocd_pkg.sv
// ----------------------------------------------------------------------------
// ocd_pkg
// shared constants, types and state encoding of the remote code decoder
// ----------------------------------------------------------------------------
package ocd_pkg;

    localparam int BUFFER_DEPTH = 52;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    localparam int IV_W       = 20;
    localparam int WIN_W      = 16;
    localparam int PCT_W      = 7;
    localparam int MCC_W      = 6;
    localparam int CODE_W     = 25;
    localparam int BITS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CMP_W      = (IDX_W > MCC_W) ? IDX_W : MCC_W;

    localparam int SYNC_PULSES = 31;
    localparam int RECIP31_SH  = IV_W;
    localparam int RECIP31     = (1 << RECIP31_SH) / SYNC_PULSES;
    localparam int PULSE_W     = 16;
    localparam int TP_W        = PULSE_W + PCT_W;
    localparam int PCT_DIV     = 100;
    localparam int RECIP100_SH = TP_W;
    localparam int RECIP100    = (1 << RECIP100_SH) / PCT_DIV;
    localparam int R100_W      = 17;
    localparam int BND_W       = 22;

    localparam logic [1:0] REPEAT_DECODE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN_GAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL_PERCENT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGE    = 2'd3;

    localparam logic [IV_W-1:0]  RST_SYNC_MIN_GAP = 20'd5000;
    localparam logic [WIN_W-1:0] RST_SYNC_WINDOW  = 16'd200;
    localparam logic [PCT_W-1:0] RST_TOL_PERCENT  = 7'd60;
    localparam logic [MCC_W-1:0] RST_MIN_CHANGE   = 6'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [IV_W-1:0]  data;
    } t_buf_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_buf_rd;

    typedef struct packed {
        logic signed [BND_W-1:0] sh_lo;
        logic signed [BND_W-1:0] sh_hi;
        logic signed [BND_W-1:0] lg_lo;
        logic signed [BND_W-1:0] lg_hi;
    } t_bounds;

endpackage

// File: sv/ocd_ibuf.sv
// ----------------------------------------------------------------------------
// ocd_ibuf
// interval store: one write port, one registered read port, per-entry valid
// ----------------------------------------------------------------------------
module ocd_ibuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ocd_pkg::t_buf_wr        i_wr,
    input  ocd_pkg::t_buf_rd        i_rd,
    output logic [ocd_pkg::IV_W-1:0] o_rd_data
);
    import ocd_pkg::*;

    logic [IV_W-1:0]         r_mem [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] r_valid;
    logic [IV_W-1:0]         r_rd_data;
    logic                    r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_hit <= r_valid[i_rd.addr];
            end
        end
    end

    // entries never written read as zero
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// File: sv/ocd_timing.sv
// ----------------------------------------------------------------------------
// ocd_timing
// pipelined unit pulse and tolerance window computation from the sync gap
// ----------------------------------------------------------------------------
module ocd_timing (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ocd_pkg::IV_W-1:0]  i_sync,
    input  logic [ocd_pkg::PCT_W-1:0] i_pct,
    output logic                      o_done,
    output ocd_pkg::t_bounds          o_bounds
);
    import ocd_pkg::*;

    localparam int PROD1_W = IV_W + PULSE_W;
    localparam int PROD2_W = TP_W + R100_W;

    logic [5:0]          r_v;
    logic [IV_W-1:0]     r_sync1;
    logic [PROD1_W-1:0]  r_prod1;
    logic [PULSE_W-1:0]  r_pulse2;
    logic [PULSE_W-1:0]  r_pulse3;
    logic [TP_W-1:0]     r_tp3;
    logic [PULSE_W-1:0]  r_pulse4;
    logic [TP_W-1:0]     r_tp4;
    logic [PROD2_W-1:0]  r_prod2;
    logic [PULSE_W-1:0]  r_pulse5;
    logic [R100_W-1:0]   r_tol5;
    t_bounds             r_bounds;

    logic [PULSE_W-1:0]  w_q31;
    logic [IV_W:0]       w_q31x;
    logic [IV_W:0]       w_rem31;
    logic [PULSE_W-1:0]  w_pulse;
    logic [R100_W-1:0]   w_q100;
    logic [TP_W-1:0]     w_q100x;
    logic [TP_W-1:0]     w_rem100;
    logic [R100_W-1:0]   w_tol;
    logic signed [BND_W-1:0] w_ps;
    logic signed [BND_W-1:0] w_pl;
    logic signed [BND_W-1:0] w_tl;

    // divide by 31: reciprocal estimate, then one correction
    assign w_q31   = r_prod1[PROD1_W-1 -: PULSE_W];
    assign w_q31x  = {w_q31, 5'b0} - (IV_W + 1)'(w_q31);
    assign w_rem31 = {1'b0, r_sync1} - w_q31x;
    assign w_pulse = (w_rem31 >= (IV_W + 1)'(SYNC_PULSES)) ? w_q31 + PULSE_W'(1) : w_q31;

    // divide by 100
    assign w_q100   = r_prod2[PROD2_W-1 -: R100_W];
    assign w_q100x  = TP_W'(w_q100) * TP_W'(PCT_DIV);
    assign w_rem100 = r_tp4 - w_q100x;
    assign w_tol    = (w_rem100 >= TP_W'(PCT_DIV)) ? w_q100 + R100_W'(1) : w_q100;

    assign w_ps = BND_W'(r_pulse5);
    assign w_pl = (w_ps <<< 1) + w_ps;
    assign w_tl = BND_W'(r_tol5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sync1  <= i_sync;
        r_prod1  <= PROD1_W'(i_sync) * PROD1_W'(RECIP31);
        r_pulse2 <= w_pulse;
        r_pulse3 <= r_pulse2;
        r_tp3    <= TP_W'(r_pulse2) * TP_W'(i_pct);
        r_pulse4 <= r_pulse3;
        r_tp4    <= r_tp3;
        r_prod2  <= PROD2_W'(r_tp3) * PROD2_W'(RECIP100);
        r_pulse5 <= r_pulse4;
        r_tol5   <= w_tol;
        r_bounds.sh_lo <= w_ps - w_tl;
        r_bounds.sh_hi <= w_ps + w_tl;
        r_bounds.lg_lo <= w_pl - w_tl;
        r_bounds.lg_hi <= w_pl + w_tl;
    end

    assign o_done   = r_v[5];
    assign o_bounds = r_bounds;

endmodule

// File: sv/ook_remote_code_decoder.sv
// ----------------------------------------------------------------------------
// ook_remote_code_decoder
// pulse width decoder for fixed code remote controls, one receiver
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) takes one edge interval per item.
//   an item that does not complete a second sync repeat is taken with no stall,
//   so such items may follow back to back.
//   an item that completes the second repeat starts a decode: a launch state,
//   the pulse/tolerance pipeline, reads of the stored interval pairs from the
//   buffer memory (single read port) up to the last full pair or a bad pair,
//   a drain of the last read, then the hand-over of the code. o_in_stall is
//   high for the whole decode, also while a held result blocks the hand-over.
//   results leave through an output register (o_out_valid / i_out_stall); a
//   held result only blocks the end of the next decode, not item intake.
//   configuration: i_cfg_valid / o_cfg_ready, ready outside reset, write
//   while idle.
//   reset: synchronous, clears counts, registers to defaults and the buffer
//   valid bits; no clearing pass; input stalled during reset.
// ----------------------------------------------------------------------------
module ook_remote_code_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ocd_pkg::IV_W-1:0]       i_edge_interval,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ocd_pkg::CODE_W-1:0]     o_sensor_code,
    output logic [ocd_pkg::BITS_W-1:0]     o_bit_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ocd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ocd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ocd_pkg::*;

    t_state r_state, n_state;

    logic [IV_W-1:0]  r_sync_min_gap;
    logic [WIN_W-1:0] r_sync_window;
    logic [PCT_W-1:0] r_tol_percent;
    logic [MCC_W-1:0] r_min_change;

    logic [CNT_W-1:0]  r_sc;
    logic [1:0]        r_rc;
    logic [IV_W-1:0]   r_sync0;
    logic [IV_W-1:0]   r_base;
    logic [IDX_W-1:0]  r_cnt;

    logic [CNT_W-1:0]  r_ptr;
    logic              r_pend;
    logic              r_pend_odd;
    logic              r_stop;
    logic              r_fs;
    logic              r_fl;
    logic [CODE_W-1:0] r_code;

    logic              r_ov;
    logic [CODE_W-1:0] r_code_out;
    logic [BITS_W-1:0] r_bits_out;

    logic              w_in_acc;
    logic [IV_W-1:0]   w_diff;
    logic              w_long;
    logic              w_sync;
    logic [1:0]        w_rc_inc;
    logic              w_hit;
    logic [CNT_W-1:0]  w_sc1;
    logic [1:0]        w_rc1;

    logic              w_tstart;
    logic              w_tdone;
    t_bounds           w_bnd;
    logic              w_walk;
    logic              w_load;
    logic [CNT_W-1:0]  w_last;
    logic              w_issue;
    logic              w_walk_end;
    logic              w_emit;
    logic [IV_W-1:0]   w_rd_data;
    logic              w_is_s;
    logic              w_is_l;

    t_buf_wr w_wr;
    t_buf_rd w_rd;

    function automatic logic in_band(input logic [IV_W-1:0] x,
                                     input logic signed [BND_W-1:0] lo,
                                     input logic signed [BND_W-1:0] hi);
        logic signed [BND_W-1:0] xs;
        xs = $signed(BND_W'(x));
        return (xs > lo) && (xs < hi);
    endfunction

    // configuration
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_min_gap <= RST_SYNC_MIN_GAP;
            r_sync_window  <= RST_SYNC_WINDOW;
            r_tol_percent  <= RST_TOL_PERCENT;
            r_min_change   <= RST_MIN_CHANGE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_MIN_GAP: r_sync_min_gap <= i_cfg_data[IV_W-1:0];
                CFG_SYNC_WINDOW:  r_sync_window  <= i_cfg_data[WIN_W-1:0];
                CFG_TOL_PERCENT:  r_tol_percent  <= i_cfg_data[PCT_W-1:0];
                CFG_MIN_CHANGE:   r_min_change   <= i_cfg_data[MCC_W-1:0];
                default: ;
            endcase
        end
    end

    // item intake: sync test, overflow, store
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_diff   = (i_edge_interval > r_sync0) ? i_edge_interval - r_sync0
                                                  : r_sync0 - i_edge_interval;
    assign w_long   = i_edge_interval > r_sync_min_gap;
    assign w_sync   = w_long && (w_diff < IV_W'(r_sync_window));
    assign w_rc_inc = r_rc + 2'd1;
    assign w_hit    = w_sync && (w_rc_inc == REPEAT_DECODE);

    always_comb begin
        w_sc1 = w_long ? '0 : r_sc;
        w_rc1 = w_sync ? (w_hit ? 2'd0 : w_rc_inc) : r_rc;
        if (w_sc1 >= CNT_W'(BUFFER_DEPTH)) begin
            w_sc1 = '0;
            w_rc1 = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc    <= '0;
            r_rc    <= 2'd0;
            r_sync0 <= '0;
        end else if (w_in_acc) begin
            r_sc <= w_sc1 + CNT_W'(1);
            r_rc <= w_rc1;
            if (w_sc1 == '0) begin
                r_sync0 <= i_edge_interval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_base <= r_sync0;
            r_cnt  <= (r_sc != '0) ? IDX_W'(r_sc - CNT_W'(1)) : '0;
        end
    end

    always_comb begin
        w_wr.en   = w_in_acc;
        w_wr.addr = IDX_W'(w_sc1);
        w_wr.data = i_edge_interval;
    end

    // decode walk
    assign w_last     = CNT_W'({r_cnt[IDX_W-1:1], 1'b0});
    assign w_issue    = w_walk && !r_stop && (r_ptr <= w_last);
    assign w_walk_end = r_stop || ((r_ptr > w_last) && !r_pend);
    assign w_is_s     = in_band(w_rd_data, w_bnd.sh_lo, w_bnd.sh_hi);
    assign w_is_l     = in_band(w_rd_data, w_bnd.lg_lo, w_bnd.lg_hi);
    assign w_emit     = (CMP_W'(r_cnt) > CMP_W'(r_min_change)) && (r_code != '0);

    always_comb begin
        w_rd.en   = w_issue;
        w_rd.addr = IDX_W'(r_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
            r_stop <= 1'b0;
        end else if (w_tstart) begin
            r_ptr  <= CNT_W'(1);
            r_pend <= 1'b0;
            r_stop <= 1'b0;
        end else begin
            r_pend <= w_issue;
            if (w_issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            if (w_walk && r_pend && !r_stop && !r_pend_odd &&
                !(r_fs && w_is_l) && !(r_fl && w_is_s)) begin
                r_stop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_odd <= r_ptr[0];
        if (w_tstart) begin
            r_code <= '0;
        end else if (w_walk && r_pend && !r_stop) begin
            if (r_pend_odd) begin
                r_fs <= w_is_s;
                r_fl <= w_is_l;
            end else if (r_fs && w_is_l) begin
                r_code <= {r_code[CODE_W-2:0], 1'b0};
            end else if (r_fl && w_is_s) begin
                r_code <= {r_code[CODE_W-2:0], 1'b1};
            end else begin
                r_code <= '0;
            end
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc && w_hit) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (w_tdone) n_state = S_WALK;
            S_WALK:  if (w_walk_end) n_state = S_DONE;
            S_DONE:  if (!(w_emit && r_ov && i_out_stall)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_tstart   = 1'b0;
        w_walk     = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_stall = !i_rst_n;
            S_START: w_tstart = 1'b1;
            S_WAIT:  ;
            S_WALK:  w_walk = 1'b1;
            S_DONE:  w_load = w_emit && !(r_ov && i_out_stall);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_code_out <= r_code;
            r_bits_out <= BITS_W'(r_cnt >> 1);
        end
    end

    assign o_out_valid   = r_ov;
    assign o_sensor_code = r_code_out;
    assign o_bit_count   = r_bits_out;

    ocd_ibuf u_ibuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    ocd_timing u_timing (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_tstart),
        .i_sync   (r_base),
        .i_pct    (r_tol_percent),
        .o_done   (w_tdone),
        .o_bounds (w_bnd)
    );

`ifndef SYNTH
    a_sc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= CNT_W'(BUFFER_DEPTH))
        else $error("stored count beyond buffer depth");

    a_rc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc == 2'd0) || (r_rc == 2'd1))
        else $error("repeat count not cleared on decode");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !(r_ov && i_out_stall))
        else $error("held result overwritten");

    a_tdone_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tdone |-> (r_state == S_WAIT))
        else $error("timing result outside wait state");

    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sensor_code != '0))
        else $error("zero code reported");
`endif

endmodule

// File: sim/tb_ook_remote_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ook_remote_code_decoder
// self-checking bench for the remote code decoder: edge intervals are sent as
// sync/data bursts, noise and overflow runs under several register settings,
// an in-bench predictor computes the codes that must come out and a checker
// compares each result with the oldest pending code, with random idling on
// both channels, a long output hold and a full sender pause
// ----------------------------------------------------------------------------
module tb_ook_remote_code_decoder;
    import ocd_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int unsigned IV_MAX        = (1 << IV_W) - 1;
    localparam int unsigned ITEM_TARGET   = 1900;
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned QUIET_LIMIT   = 20000;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] nbits;
    } t_code_rec;

    typedef enum int {
        BURST_CLEAN,
        BURST_BAD_PAIR,
        BURST_OVERFLOW,
        BURST_NOISE
    } t_burst_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [IV_W-1:0]       i_edge_interval;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CODE_W-1:0]     o_sensor_code;
    logic [BITS_W-1:0]     o_bit_count;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predictor state and register copies
    logic [IV_W-1:0]  iv_mem [BUFFER_DEPTH];
    int unsigned      iv_count;
    logic [1:0]       repeat_seen;
    logic [IV_W-1:0]  gap_min;
    logic [WIN_W-1:0] sync_win;
    logic [PCT_W-1:0] tol_pct;
    logic [MCC_W-1:0] min_changes;

    t_code_rec   expected_codes[$];
    int unsigned items_sent    = 0;
    int unsigned fail_count    = 0;
    int unsigned hold_request  = 0;
    int unsigned quiet_cycles  = 0;
    bit          in_calm       = 1'b0;
    bit          out_calm      = 1'b0;

    ook_remote_code_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_edge_interval (i_edge_interval),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sensor_code   (o_sensor_code),
        .o_bit_count     (o_bit_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void reset_model();
        for (int i = 0; i < BUFFER_DEPTH; i++) begin
            iv_mem[i] = '0;
        end
        iv_count    = 0;
        repeat_seen = '0;
        gap_min     = RST_SYNC_MIN_GAP;
        sync_win    = RST_SYNC_WINDOW;
        tol_pct     = RST_TOL_PERCENT;
        min_changes = RST_MIN_CHANGE;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SYNC_MIN_GAP: gap_min     = data[IV_W-1:0];
            CFG_SYNC_WINDOW:  sync_win    = data[WIN_W-1:0];
            CFG_TOL_PERCENT:  tol_pct     = data[PCT_W-1:0];
            CFG_MIN_CHANGE:   min_changes = data[MCC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit in_window(longint x, longint centre, longint tol);
        return (x > centre - tol) && (x < centre + tol);
    endfunction

    // walks stored pairs after the sync, returns 1 when a code is to be reported
    function automatic bit decode_stored_code(int unsigned n, output t_code_rec rec);
        longint            pulse;
        longint            plong;
        longint            tol;
        longint            a;
        longint            b;
        logic [CODE_W-1:0] code;
        int unsigned       i;
        bit                bad;
        pulse = longint'(iv_mem[0] / SYNC_PULSES);
        plong = pulse * 3;
        tol   = (pulse * longint'(tol_pct)) / 100;
        code  = '0;
        bad   = 1'b0;
        i     = 1;
        while (i < n && i + 1 < BUFFER_DEPTH + 1 && !bad) begin
            a = longint'(iv_mem[i % BUFFER_DEPTH]);
            b = longint'(iv_mem[(i + 1) % BUFFER_DEPTH]);
            if (in_window(a, pulse, tol) && in_window(b, plong, tol)) begin
                code = {code[CODE_W-2:0], 1'b0};
            end else if (in_window(a, plong, tol) && in_window(b, pulse, tol)) begin
                code = {code[CODE_W-2:0], 1'b1};
            end else begin
                code = '0;
                bad  = 1'b1;
            end
            i += 2;
        end
        rec.code  = code;
        rec.nbits = BITS_W'(n / 2);
        return (n > min_changes) && (code != '0);
    endfunction

    function automatic void take_interval(logic [IV_W-1:0] iv);
        logic [IV_W-1:0] sync0;
        logic [IV_W-1:0] diff;
        int unsigned     n;
        t_code_rec       rec;
        sync0 = iv_mem[0];
        diff  = (iv > sync0) ? iv - sync0 : sync0 - iv;
        if (iv > gap_min && diff < sync_win) begin
            n = (iv_count > 0) ? iv_count - 1 : 0;
            repeat_seen = repeat_seen + 2'd1;
            if (repeat_seen == REPEAT_DECODE) begin
                if (decode_stored_code(n, rec)) begin
                    expected_codes.push_back(rec);
                end
                repeat_seen = '0;
            end
            iv_count = 0;
        end else if (iv > gap_min) begin
            iv_count = 0;
        end
        if (iv_count >= BUFFER_DEPTH) begin
            iv_count    = 0;
            repeat_seen = '0;
        end
        iv_mem[iv_count] = iv;
        iv_count++;
    endfunction

    function automatic int unsigned pick_in_gap();
        int unsigned r;
        if (in_calm) begin
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(20, 4);
        return $urandom_range(120, 40);
    endfunction

    function automatic int unsigned pick_out_stall();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(3, 1);
        if (r < 99) return $urandom_range(20, 4);
        return $urandom_range(80, 30);
    endfunction

    function automatic logic [IV_W-1:0] clamp_iv(longint v);
        if (v < 0) return '0;
        if (v > longint'(IV_MAX)) return IV_W'(IV_MAX);
        return IV_W'(v);
    endfunction

    function automatic logic [IV_W-1:0] random_noise();
        case ($urandom_range(3, 0))
            0: return IV_W'($urandom);
            1: return IV_W'($urandom_range(4000, 0));
            2: return $urandom_range(1, 0) ? IV_W'(IV_MAX) : '0;
            default: return clamp_iv(longint'(gap_min) + longint'($urandom_range(400, 0)) - 200);
        endcase
    endfunction

    function automatic logic [IV_W-1:0] pick_sync();
        int unsigned lo;
        int unsigned hi;
        if (gap_min == IV_W'(IV_MAX)) begin
            return random_noise();
        end
        lo = gap_min + 1;
        hi = lo + lo / 2 + 1000;
        if (hi > IV_MAX) hi = IV_MAX;
        return IV_W'($urandom_range(hi, lo));
    endfunction

    // short or long interval around the unit pulse of the given sync
    function automatic logic [IV_W-1:0] shaped_interval(logic [IV_W-1:0] sync_iv, bit is_long);
        longint p;
        longint t;
        longint c;
        p = longint'(sync_iv / SYNC_PULSES);
        t = (p * longint'(tol_pct)) / 100;
        c = is_long ? 3 * p : p;
        if (t > 1) begin
            c = c - (t - 1) + longint'($urandom_range(int'(2 * t - 2), 0));
        end
        return clamp_iv(c);
    endfunction

    function automatic logic [IV_W-1:0] jittered(logic [IV_W-1:0] sync_iv);
        longint      v;
        int unsigned j;
        v = longint'(sync_iv);
        if (sync_win < 2) begin
            return sync_iv;
        end
        j = $urandom_range((sync_win - 1) / 2, 0);
        v = $urandom_range(1, 0) ? v + j : v - j;
        return clamp_iv(v);
    endfunction

    // leaves valid high when the next item follows at once
    task automatic send_interval(input logic [IV_W-1:0] iv);
        int unsigned gap;
        i_in_valid      <= 1'b1;
        i_edge_interval <= iv;
        do @(posedge i_clk); while (o_in_stall);
        take_interval(iv);
        items_sent++;
        gap = pick_in_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, data);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] gap, input logic [CFG_DATA_W-1:0] win,
                              input logic [CFG_DATA_W-1:0] pct, input logic [CFG_DATA_W-1:0] mcc);
        wait_idle();
        cfg_write(CFG_SYNC_MIN_GAP, gap);
        cfg_write(CFG_SYNC_WINDOW, win);
        cfg_write(CFG_TOL_PERCENT, pct);
        cfg_write(CFG_MIN_CHANGE, mcc);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_burst(input t_burst_kind kind, input int unsigned npairs);
        logic [IV_W-1:0]   sync_iv;
        logic [CODE_W-1:0] pattern;
        int unsigned       reps;
        int unsigned       bad_at;
        int unsigned       n;
        bit                tail;
        sync_iv = pick_sync();
        pattern = CODE_W'($urandom);
        reps    = $urandom_range(3, 2);
        tail    = ($urandom_range(1, 0) != 0);
        bad_at  = $urandom_range(2 * npairs - 1, 0);
        send_interval(sync_iv);
        case (kind)
            BURST_NOISE: begin
                n = $urandom_range(12, 1);
                repeat (n) send_interval(random_noise());
            end
            BURST_OVERFLOW: begin
                n = $urandom_range(BUFFER_DEPTH + 20, BUFFER_DEPTH);
                repeat (n) send_interval(shaped_interval(sync_iv, $urandom_range(1, 0) != 0));
                send_interval(jittered(sync_iv));
            end
            default: begin
                for (int unsigned r = 0; r < reps; r++) begin
                    for (int unsigned k = 0; k < 2 * npairs; k++) begin
                        if (kind == BURST_BAD_PAIR && r == reps - 1 && k == bad_at) begin
                            send_interval(random_noise());
                        end else begin
                            send_interval(shaped_interval(sync_iv, pattern[k / 2] ^ k[0]));
                        end
                    end
                    if (tail) begin
                        send_interval(shaped_interval(sync_iv, 1'b0));
                    end
                    send_interval(jittered(sync_iv));
                end
            end
        endcase
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned npairs;
        t_burst_kind kind;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) kind = BURST_CLEAN;
            else if (pick < 80) kind = BURST_BAD_PAIR;
            else if (pick < 88) kind = BURST_OVERFLOW;
            else kind = BURST_NOISE;
            npairs  = ($urandom_range(4, 0) == 0) ? $urandom_range(CODE_W, 13) : $urandom_range(12, 1);
            in_calm = ($urandom_range(9, 0) == 0);
            send_burst(kind, npairs);
        end
    endtask

    // field extremes, then one clean four-bit word under reset settings
    task automatic test_directed();
        send_interval('0);
        send_interval(IV_W'(IV_MAX));
        send_interval(IV_W'(6200));
        for (int r = 0; r < 2; r++) begin
            send_interval(IV_W'(600));
            send_interval(IV_W'(200));
            send_interval(IV_W'(200));
            send_interval(IV_W'(600));
            send_interval(IV_W'(600));
            send_interval(IV_W'(200));
            send_interval(IV_W'(600));
            send_interval(IV_W'(200));
            send_interval((r == 0) ? IV_W'(6250) : IV_W'(6180));
        end
        wait_idle();
    endtask

    task automatic test_config_extremes();
        set_config('0, '0, '0, '0);
        run_random(100);
        set_config(CFG_DATA_W'(IV_MAX), CFG_DATA_W'((1 << WIN_W) - 1), CFG_DATA_W'(100),
                   CFG_DATA_W'((1 << MCC_W) - 1));
        run_random(100);
        wait_idle();
    endtask

    task automatic test_mixed_settings();
        set_config(CFG_DATA_W'(20000), CFG_DATA_W'((1 << WIN_W) - 1), CFG_DATA_W'(100), '0);
        run_random(250);
        set_config(CFG_DATA_W'(3000), CFG_DATA_W'(2000), CFG_DATA_W'(25), CFG_DATA_W'(10));
        run_random(200);
        repeat (2) begin
            set_config(CFG_DATA_W'($urandom_range(60000, 1000)),
                       CFG_DATA_W'($urandom_range(5000, 50)),
                       CFG_DATA_W'($urandom_range(100, 10)),
                       CFG_DATA_W'($urandom_range(20, 0)));
            run_random(150);
        end
        wait_idle();
    endtask

    // output held for a long stretch while short words keep coming in
    task automatic test_backpressure();
        int unsigned stop_at;
        set_config(CFG_DATA_W'(RST_SYNC_MIN_GAP), CFG_DATA_W'(RST_SYNC_WINDOW),
                   CFG_DATA_W'(RST_TOL_PERCENT), CFG_DATA_W'(RST_MIN_CHANGE));
        in_calm      = 1'b1;
        hold_request = HOLD_CYCLES;
        stop_at      = items_sent + 200;
        while (items_sent < stop_at) begin
            send_burst(BURST_CLEAN, $urandom_range(8, 4));
        end
        in_calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_sender_pause();
        set_config(CFG_DATA_W'(8000), CFG_DATA_W'(400), CFG_DATA_W'(40), CFG_DATA_W'(4));
        repeat (4) begin
            send_burst(BURST_CLEAN, $urandom_range(10, 5));
            wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        set_config(CFG_DATA_W'(RST_SYNC_MIN_GAP), CFG_DATA_W'(RST_SYNC_WINDOW),
                   CFG_DATA_W'(RST_TOL_PERCENT), CFG_DATA_W'(RST_MIN_CHANGE));
        while (items_sent < ITEM_TARGET) begin
            run_random(100);
        end
        wait_idle();
    endtask

    initial begin : out_stall_gen
        int unsigned stall_left;
        stall_left  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0) begin
                if ($urandom_range(199, 0) == 0) out_calm = !out_calm;
                stall_left = out_calm ? 0 : pick_out_stall();
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_code_rec want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_codes.size() == 0) begin
                $error("unexpected result: sensor_code %h bit_count %0d", o_sensor_code, o_bit_count);
                fail_count++;
            end else begin
                want = expected_codes.pop_front();
                if (o_sensor_code !== want.code) begin
                    $error("sensor_code mismatch: expected %h, actual %h", want.code, o_sensor_code);
                    fail_count++;
                end
                if (o_bit_count !== want.nbits) begin
                    $error("bit_count mismatch: expected %0d, actual %0d", want.nbits, o_bit_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_ook_remote_code_decoder: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_edge_interval = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_SYNC_MIN_GAP;
        i_cfg_data      = '0;
        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_mixed_settings();
        test_backpressure();
        test_sender_pause();
        test_random_traffic();

        if (expected_codes.size() != 0) begin
            $error("%0d expected results never arrived", expected_codes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("tb_ook_remote_code_decoder: PASS");
        end else begin
            $display("tb_ook_remote_code_decoder: FAIL");
        end
        $finish;
    end

endmodule

// File: ook_remote_code_decoder.f
sv/ocd_pkg.sv
sv/ocd_ibuf.sv
sv/ocd_timing.sv
sv/ook_remote_code_decoder.sv
sim/tb_ook_remote_code_decoder.sv
